// ===== rtl/core/cset_pkg.sv =====
// shared types and constants for the call stack exclusive time block
package cset_pkg;

   // fixed field widths of the request and response
   localparam int ID_BITS     = 7;
   localparam int TS_BITS     = 32;
   localparam int DEPTH_BITS  = 7;
   localparam int STATUS_BITS = 2;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_UNDERFLOW = 2'd2;

   // one enter or exit event
   typedef struct packed {
      logic [ID_BITS-1:0] func_id;
      logic               is_enter;
      logic [TS_BITS-1:0] timestamp;
   } cset_req_type;

   // one credit report
   typedef struct packed {
      logic                   credit_valid;
      logic [ID_BITS-1:0]     credited_id;
      logic [TS_BITS-1:0]     credited_total;
      logic [DEPTH_BITS-1:0]  stack_depth;
      logic [STATUS_BITS-1:0] status;
   } cset_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic execute;
      logic clear;
   } cset_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic out_busy;
   } cset_sts_type;

endpackage

// ===== rtl/core/cset_ram.sv =====
// generic single write port ram with registered read
module cset_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/cset_ctrl.sv =====
// controller state machine: clearing sweep, idle and execute
module cset_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cset_pkg::cset_sts_type sts,
   output cset_pkg::cset_cmd_type cmd
);
   import cset_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // take a request only when idle and the output register will be free
   assign req_ready = (state_ff == ST_IDLE) && !sts.out_busy;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      cmd.load    = accept;
      cmd.execute = (state_ff == ST_EXEC);
      cmd.clear   = (state_ff == ST_CLEAR);
   end

endmodule

// ===== rtl/core/cset_dp.sv =====
// datapath: totals and stack memories, mark, stack pointer, output register
module cset_dp #(
   parameter int NUM_FUNCS   = 128,
   parameter int STACK_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cset_pkg::cset_req_type req_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output cset_pkg::cset_rsp_type rsp_data,
   input  cset_pkg::cset_cmd_type cmd,
   output cset_pkg::cset_sts_type sts
);
   import cset_pkg::*;

   localparam int FID_W = $clog2(NUM_FUNCS);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int TB    = TIME_BITS;
   localparam int NIDS  = 2 ** ID_BITS;
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};

   // id reduction table, built at elaboration
   logic [FID_W-1:0] id_tbl [NIDS];
   for (genvar g = 0; g < NIDS; g++) begin : g_id_tbl
      assign id_tbl[g] = FID_W'(g % NUM_FUNCS);
   end

   logic [FID_W-1:0] clr_ff, clr_in;
   logic [FID_W-1:0] id_ff;
   logic             enter_ff;
   logic [TB-1:0]    t_ff;
   logic [TB-1:0]    delta_ff, delta_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [TB-1:0]    mark_ff, mark_in;
   logic [FID_W-1:0] top_ff, top_in;
   logic             rsp_valid_ff;
   cset_rsp_type     rsp_ff, rsp_in;

   logic [TB+TS_BITS-1:0]     t_wide;
   logic [TB-1:0]             t_req;
   logic [TB:0]               diff;
   logic [SP_W-1:0]           sp_m2;
   logic [TB-1:0]             tot_rd;
   logic [FID_W-1:0]          stk_rd;
   logic [TB:0]               sum;
   logic [TB-1:0]             new_total;
   logic                      has_top;
   logic                      full;
   logic                      tot_we;
   logic [FID_W-1:0]          tot_waddr;
   logic [TB-1:0]             tot_wdata;
   logic                      stk_we;
   logic [FID_W+ID_BITS-1:0]  cid_wide;
   logic [TB+TS_BITS-1:0]     tot_wide;
   logic [SP_W+DEPTH_BITS-1:0] depth_wide;

   // request timestamp at the internal time width
   assign t_wide = {{TB{1'b0}}, req_data.timestamp};
   assign t_req  = t_wide[TB-1:0];

   // elapsed time at accept, plus one for an exit, floored and saturated
   assign diff = {1'b0, t_req} - {1'b0, mark_ff} + {{TB{1'b0}}, ~req_data.is_enter};
   always_comb begin
      if (t_req < mark_ff) begin
         delta_in = '0;
      end else if (diff[TB]) begin
         delta_in = TMAX;
      end else begin
         delta_in = diff[TB-1:0];
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff    <= id_tbl[req_data.func_id];
         enter_ff <= req_data.is_enter;
         t_ff     <= t_req;
         delta_ff <= delta_in;
      end
   end

   // clearing sweep over the totals
   assign clr_in         = clr_ff + FID_W'(1);
   assign sts.clear_last = cmd.clear && (clr_ff == FID_W'(NUM_FUNCS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_in;
      end
   end

   // saturating total update
   assign has_top   = (sp_ff != '0);
   assign full      = (sp_ff == SP_W'(STACK_DEPTH));
   assign sum       = {1'b0, tot_rd} + {1'b0, delta_ff};
   assign new_total = sum[TB] ? TMAX : sum[TB-1:0];

   // totals memory port muxing
   always_comb begin
      if (cmd.clear) begin
         tot_we    = 1'b1;
         tot_waddr = clr_ff;
         tot_wdata = '0;
      end else begin
         tot_we    = cmd.execute && has_top;
         tot_waddr = top_ff;
         tot_wdata = new_total;
      end
   end

   assign stk_we = cmd.execute && enter_ff && !full;
   assign sp_m2  = sp_ff - SP_W'(2);

   cset_ram #(
      .WIDTH (TB),
      .DEPTH (NUM_FUNCS)
   ) u_totals (
      .clock (clock),
      .we    (tot_we),
      .waddr (tot_waddr),
      .wdata (tot_wdata),
      .re    (cmd.load),
      .raddr (top_ff),
      .rdata (tot_rd)
   );

   cset_ram #(
      .WIDTH (FID_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (sp_ff[SA_W-1:0]),
      .wdata (id_ff),
      .re    (cmd.load),
      .raddr (sp_m2[SA_W-1:0]),
      .rdata (stk_rd)
   );

   // event execution
   always_comb begin
      sp_in   = sp_ff;
      mark_in = mark_ff;
      top_in  = top_ff;
      rsp_in  = '0;
      rsp_in.credit_valid = has_top;
      if (enter_ff) begin
         mark_in = t_ff;
         if (full) begin
            rsp_in.status = STAT_OVERFLOW;
         end else begin
            sp_in  = sp_ff + SP_W'(1);
            top_in = id_ff;
         end
      end else begin
         if (!has_top) begin
            rsp_in.status = STAT_UNDERFLOW;
         end else begin
            sp_in   = sp_ff - SP_W'(1);
            top_in  = stk_rd;
            mark_in = (t_ff == TMAX) ? TMAX : t_ff + TB'(1);
         end
      end
      if (has_top) begin
         rsp_in.credited_id    = cid_wide[ID_BITS-1:0];
         rsp_in.credited_total = tot_wide[TS_BITS-1:0];
      end
      rsp_in.stack_depth = depth_wide[DEPTH_BITS-1:0];
   end

   assign cid_wide   = {{ID_BITS{1'b0}}, top_ff};
   assign tot_wide   = {{TS_BITS{1'b0}}, new_total};
   assign depth_wide = {{DEPTH_BITS{1'b0}}, sp_in};

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff   <= '0;
         mark_ff <= '0;
         top_ff  <= '0;
      end else if (cmd.execute) begin
         sp_ff   <= sp_in;
         mark_ff <= mark_in;
         top_ff  <= top_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ===== rtl/core/call_stack_exclusive_time.sv =====
// top level of the call stack exclusive time block
// Usage:
//   req channel carries one function enter or exit event per request
//   (func_id, is_enter, timestamp); rsp channel returns one credit report
//   per request (credit_valid, credited_id, credited_total, stack_depth,
//   status). Both use valid/ready.
// Timing:
//   a request is accepted in the idle state and executed in the next cycle;
//   the response is valid the cycle after that. Each request passes through
//   the registered read of the totals memory and then its read-modify-write;
//   no new request is accepted until the execute state returns to idle.
// Reset:
//   synchronous reset empties the stack and zeroes the mark, then a clearing
//   pass writes zero to every total, during which req_ready stays low.
// Stalls:
//   the response waits in an output register while rsp_ready is low; a new
//   request is accepted only when that register is empty or its response
//   is taken in the same cycle, so a held response is never overwritten.
module call_stack_exclusive_time #(
   parameter int NUM_FUNCS   = 128,
   parameter int STACK_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cset_pkg::cset_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cset_pkg::cset_rsp_type rsp_data
);
   import cset_pkg::*;

   cset_cmd_type cmd;
   cset_sts_type sts;

   // controller
   cset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   cset_dp #(
      .NUM_FUNCS   (NUM_FUNCS),
      .STACK_DEPTH (STACK_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== rtl/core/cset_chk.sv =====
// port level checks for the call stack exclusive time block
module cset_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input cset_pkg::cset_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cset_pkg::cset_rsp_type rsp_data
);
   import cset_pkg::*;

   // no response straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // no credit means zeroed id and total
   a_no_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.credit_valid |->
         rsp_data.credited_id == '0 && rsp_data.credited_total == '0)
      else $error("uncredited response carries id or total");

   // exit on empty stack leaves it empty and credits nothing
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_UNDERFLOW |->
         rsp_data.stack_depth == '0 && !rsp_data.credit_valid)
      else $error("underflow response inconsistent");

   // an accepted request is followed by a busy cycle
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

endmodule

bind call_stack_exclusive_time cset_chk u_chk (.*);
